>>> hw/rtl/aesi_pkg.sv
// shared types and constants of the escape sequence interpreter
package aesi_pkg;

  // field widths
  localparam int COL_W   = 7;   // cursor column, enough for the widest screen
  localparam int ROW_W   = 6;   // cursor row, enough for the tallest screen
  localparam int NUM_W   = 16;  // collected decimal number
  localparam int CHAR_W  = 8;
  localparam int LROW_W  = 5;   // row width on the ports
  localparam int CFG_IDX_W = 1;
  localparam int MAX_REQ = 3;
  localparam int REQ_IDX_W = 2;

  localparam logic [NUM_W-1:0] NUM_SAT = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEFT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RIGHT = 1'b1;

  localparam logic [COL_W-1:0] STEP_LEFT_RST  = 7'd0;
  localparam logic [COL_W-1:0] STEP_RIGHT_RST = 7'd79;

  // status flag codes
  localparam logic [1:0] STAT_NONE  = 2'd0;
  localparam logic [1:0] STAT_PAREN = 2'd1;
  localparam logic [1:0] STAT_QUERY = 2'd2;

  // request kinds
  typedef enum logic [1:0] {
    REQ_NONE  = 2'd0,
    REQ_ATTR  = 2'd1,
    REQ_ERASE = 2'd2
  } req_kind_t;

  // character codes
  localparam logic [CHAR_W-1:0] CH_ESC      = 8'h1B;
  localparam logic [CHAR_W-1:0] CH_SHIFT_IN = 8'h0F;
  localparam logic [CHAR_W-1:0] CH_LBRACK   = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_LPAREN   = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_RPAREN   = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_QUERY    = 8'h3F;  // ?
  localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;  // ;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP       = 8'h41;  // A
  localparam logic [CHAR_W-1:0] CH_DOWN     = 8'h42;  // B
  localparam logic [CHAR_W-1:0] CH_RIGHT    = 8'h43;  // C
  localparam logic [CHAR_W-1:0] CH_LEFT     = 8'h44;  // D
  localparam logic [CHAR_W-1:0] CH_POS      = 8'h48;  // H
  localparam logic [CHAR_W-1:0] CH_ERASE_S  = 8'h4A;  // J
  localparam logic [CHAR_W-1:0] CH_ERASE_L  = 8'h4B;  // K
  localparam logic [CHAR_W-1:0] CH_UP_L     = 8'h4C;  // L
  localparam logic [CHAR_W-1:0] CH_POS_F    = 8'h66;  // f
  localparam logic [CHAR_W-1:0] CH_SET_MODE = 8'h68;  // h
  localparam logic [CHAR_W-1:0] CH_RST_MODE = 8'h6C;  // l
  localparam logic [CHAR_W-1:0] CH_ATTR     = 8'h6D;  // m
  localparam logic [CHAR_W-1:0] CH_REGION   = 8'h72;  // r
  localparam logic [CHAR_W-1:0] CH_SAVE     = 8'h73;  // s
  localparam logic [CHAR_W-1:0] CH_RESTORE  = 8'h75;  // u

  // one classified item as handed from the parser to the result sequencer
  typedef struct packed {
    logic                               handled;
    logic [REQ_IDX_W-1:0]               last_idx;
    req_kind_t [MAX_REQ-1:0]            kind;
    logic [MAX_REQ-1:0][NUM_W-1:0]      value;
    logic [COL_W-1:0]                   col;
    logic [ROW_W-1:0]                   row;
  } job_t;

  // decimal accumulate with saturation
  function automatic logic [NUM_W-1:0] acc_digit(input logic [NUM_W-1:0] acc,
                                                 input logic [3:0] dig);
    logic [NUM_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{NUM_W{1'b0}}, dig};
    return (v > {4'b0, NUM_SAT}) ? NUM_SAT : v[NUM_W-1:0];
  endfunction

endpackage

>>> hw/rtl/aesi_front.sv
// parser front end: decodes each transaction, updates cursor state, builds a job
module aesi_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [aesi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aesi_pkg::COL_W-1:0]         cfg_wdata,
  input  logic                               accept,
  input  logic                               mode,
  input  logic [aesi_pkg::CHAR_W-1:0]        char_code,
  input  logic [aesi_pkg::COL_W-1:0]         load_col,
  input  logic [aesi_pkg::LROW_W-1:0]        load_row,
  output aesi_pkg::job_t                     job
);

  localparam int COL_W = aesi_pkg::COL_W;
  localparam int ROW_W = aesi_pkg::ROW_W;
  localparam int NUM_W = aesi_pkg::NUM_W;
  localparam logic [COL_W-1:0] COL_MAX = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(ROWS - 1);
  localparam logic [NUM_W-1:0] SCREEN  = NUM_W'(ROWS * COLUMNS);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ESC  = 3'd1,
    PH_CSI  = 3'd2,
    PH_NUM1 = 3'd3,
    PH_NUM2 = 3'd4,
    PH_NUM3 = 3'd5
  } phase_t;

  phase_t             phase_r, phase_nxt;
  logic [NUM_W-1:0]   first_r, first_nxt;
  logic [NUM_W-1:0]   second_r, second_nxt;
  logic [NUM_W-1:0]   third_r, third_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COL_W-1:0]   scol_r, scol_nxt;
  logic [ROW_W-1:0]   srow_r, srow_nxt;
  logic               svalid_r, svalid_nxt;
  logic [COL_W-1:0]   left_r;
  logic [COL_W-1:0]   right_r;

  logic               is_dig;
  logic [3:0]         dig;
  logic [NUM_W-1:0]   acc_in;
  logic [NUM_W-1:0]   acc_out;
  logic [NUM_W-1:0]   erase_scr;
  logic [NUM_W-1:0]   erase_line;
  logic [NUM_W-1:0]   row_room;
  logic [NUM_W-1:0]   col_room;
  logic [ROW_W-1:0]   lrow_ext;

  // shared decimal accumulator, fed from the number being collected
  assign is_dig = (char_code >= aesi_pkg::CH_ZERO) && (char_code <= aesi_pkg::CH_NINE);
  assign dig    = char_code[3:0];
  always_comb begin
    case (phase_r)
      PH_NUM1: acc_in = first_r;
      PH_NUM2: acc_in = second_r;
      default: acc_in = third_r;
    endcase
  end
  assign acc_out = aesi_pkg::acc_digit(acc_in, dig);

  // erase counts and room left for relative moves
  assign erase_scr  = NUM_W'((NUM_W'(ROWS) - NUM_W'(row_r)) * NUM_W'(COLUMNS))
                      - NUM_W'(col_r);
  assign erase_line = NUM_W'(COLUMNS) - NUM_W'(col_r);
  assign row_room   = NUM_W'(ROW_MAX - row_r);
  assign col_room   = NUM_W'(COL_MAX - col_r);
  assign lrow_ext   = ROW_W'(load_row);

  // next state and job contents
  always_comb begin
    phase_nxt  = PH_IDLE;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    status_nxt = status_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    scol_nxt   = scol_r;
    srow_nxt   = srow_r;
    svalid_nxt = svalid_r;
    job        = '0;
    job.kind   = {aesi_pkg::REQ_NONE, aesi_pkg::REQ_NONE, aesi_pkg::REQ_NONE};

    if (mode) begin
      phase_nxt = phase_r;
      col_nxt   = (load_col > COL_MAX) ? COL_MAX : load_col;
      row_nxt   = (lrow_ext > ROW_MAX) ? ROW_MAX : lrow_ext;
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (char_code == aesi_pkg::CH_ESC) begin
            phase_nxt   = PH_ESC;
            job.handled = 1'b1;
          end
        end
        PH_ESC: begin
          if (char_code == aesi_pkg::CH_LBRACK || char_code == aesi_pkg::CH_LPAREN ||
              char_code == aesi_pkg::CH_RPAREN) begin
            first_nxt   = '0;
            phase_nxt   = PH_CSI;
            job.handled = 1'b1;
            if (char_code == aesi_pkg::CH_RPAREN) begin
              status_nxt = aesi_pkg::STAT_PAREN;
            end
          end
        end
        PH_CSI: begin
          job.handled = 1'b1;
          if (is_dig) begin
            first_nxt = NUM_W'(dig);
            phase_nxt = (status_r == aesi_pkg::STAT_PAREN) ? PH_IDLE : PH_NUM1;
          end else begin
            unique case (char_code) inside
              aesi_pkg::CH_ATTR: begin
                job.kind[0] = aesi_pkg::REQ_ATTR;
              end
              aesi_pkg::CH_SAVE: begin
                scol_nxt   = col_r;
                srow_nxt   = row_r;
                svalid_nxt = 1'b1;
              end
              aesi_pkg::CH_RESTORE: begin
                if (svalid_r) begin
                  col_nxt    = scol_r;
                  row_nxt    = srow_r;
                  svalid_nxt = 1'b0;
                end
              end
              aesi_pkg::CH_POS: begin
                col_nxt = '0;
                row_nxt = '0;
              end
              aesi_pkg::CH_ERASE_S: begin
                job.kind[0]  = aesi_pkg::REQ_ERASE;
                job.value[0] = erase_scr;
              end
              aesi_pkg::CH_ERASE_L: begin
                job.kind[0]  = aesi_pkg::REQ_ERASE;
                job.value[0] = erase_line;
              end
              aesi_pkg::CH_UP, aesi_pkg::CH_DOWN: begin
              end
              aesi_pkg::CH_RIGHT: begin
                if (col_r < right_r && col_r < COL_MAX) col_nxt = col_r + 1'b1;
              end
              aesi_pkg::CH_LEFT: begin
                if (col_r > left_r) col_nxt = col_r - 1'b1;
              end
              default: job.handled = 1'b0;
            endcase
          end
        end
        PH_NUM1: begin
          job.handled = 1'b1;
          if (is_dig) begin
            first_nxt = acc_out;
            phase_nxt = PH_NUM1;
          end else begin
            unique case (char_code) inside
              aesi_pkg::CH_SET_MODE: begin
              end
              aesi_pkg::CH_QUERY: begin
                status_nxt = aesi_pkg::STAT_QUERY;
                second_nxt = '0;
                phase_nxt  = PH_NUM2;
              end
              aesi_pkg::CH_SEMI: begin
                second_nxt = '0;
                phase_nxt  = PH_NUM2;
              end
              aesi_pkg::CH_ERASE_S: begin
                if (first_r == NUM_W'(2)) begin
                  col_nxt      = '0;
                  row_nxt      = '0;
                  job.kind[0]  = aesi_pkg::REQ_ERASE;
                  job.value[0] = SCREEN;
                end else begin
                  job.handled = 1'b0;
                end
              end
              aesi_pkg::CH_ATTR: begin
                job.kind[0]  = aesi_pkg::REQ_ATTR;
                job.value[0] = first_r;
              end
              aesi_pkg::CH_UP: begin
                row_nxt = (first_r > NUM_W'(row_r)) ? '0 : row_r - first_r[ROW_W-1:0];
              end
              aesi_pkg::CH_DOWN: begin
                row_nxt = (first_r >= row_room) ? ROW_MAX : row_r + first_r[ROW_W-1:0];
              end
              aesi_pkg::CH_RIGHT: begin
                col_nxt = (first_r >= col_room) ? COL_MAX : col_r + first_r[COL_W-1:0];
              end
              aesi_pkg::CH_LEFT: begin
                col_nxt = (first_r > NUM_W'(col_r)) ? '0 : col_r - first_r[COL_W-1:0];
              end
              default: job.handled = 1'b0;
            endcase
          end
        end
        PH_NUM2: begin
          job.handled = 1'b1;
          if (is_dig) begin
            second_nxt = acc_out;
            phase_nxt  = PH_NUM2;
          end else begin
            unique case (char_code) inside
              aesi_pkg::CH_SEMI: begin
                third_nxt = '0;
                phase_nxt = PH_NUM3;
              end
              aesi_pkg::CH_POS, aesi_pkg::CH_POS_F: begin
                // absolute place, numbers count from one
                if (second_r == '0)                  col_nxt = '0;
                else if (second_r > NUM_W'(COLUMNS)) col_nxt = COL_MAX;
                else                                 col_nxt = COL_W'(second_r - 1'b1);
                if (first_r == '0)                   row_nxt = '0;
                else if (first_r > NUM_W'(ROWS))     row_nxt = ROW_MAX;
                else                                 row_nxt = ROW_W'(first_r - 1'b1);
              end
              aesi_pkg::CH_ATTR: begin
                job.kind[0]  = aesi_pkg::REQ_ATTR;
                job.value[0] = first_r;
                job.kind[1]  = aesi_pkg::REQ_ATTR;
                job.value[1] = second_r;
                job.last_idx = 2'd1;
              end
              aesi_pkg::CH_RST_MODE, aesi_pkg::CH_UP_L, aesi_pkg::CH_SET_MODE,
              aesi_pkg::CH_REGION, aesi_pkg::CH_SHIFT_IN: begin
              end
              aesi_pkg::CH_ERASE_S: begin
                col_nxt      = '0;
                row_nxt      = '0;
                job.kind[0]  = aesi_pkg::REQ_ERASE;
                job.value[0] = SCREEN;
              end
              default: job.handled = 1'b0;
            endcase
          end
        end
        PH_NUM3: begin
          job.handled = 1'b1;
          if (is_dig) begin
            third_nxt = acc_out;
            phase_nxt = PH_NUM3;
          end else if (char_code == aesi_pkg::CH_ATTR) begin
            job.kind     = {aesi_pkg::REQ_ATTR, aesi_pkg::REQ_ATTR, aesi_pkg::REQ_ATTR};
            job.value[0] = first_r;
            job.value[1] = second_r;
            job.value[2] = third_r;
            job.last_idx = 2'd2;
          end else begin
            job.handled = 1'b0;
          end
        end
        default: job.handled = 1'b0;
      endcase
    end
    job.col = col_nxt;
    job.row = row_nxt;
  end

  // parser state, cursor and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      first_r  <= '0;
      second_r <= '0;
      third_r  <= '0;
      status_r <= aesi_pkg::STAT_NONE;
      col_r    <= '0;
      row_r    <= '0;
      scol_r   <= '0;
      srow_r   <= '0;
      svalid_r <= 1'b0;
      left_r   <= aesi_pkg::STEP_LEFT_RST;
      right_r  <= aesi_pkg::STEP_RIGHT_RST;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        first_r  <= first_nxt;
        second_r <= second_nxt;
        third_r  <= third_nxt;
        status_r <= status_nxt;
        col_r    <= col_nxt;
        row_r    <= row_nxt;
        scol_r   <= scol_nxt;
        srow_r   <= srow_nxt;
        svalid_r <= svalid_nxt;
      end
      if (cfg_we) begin
        if (cfg_index == aesi_pkg::CFG_STEP_LEFT)  left_r  <= cfg_wdata;
        if (cfg_index == aesi_pkg::CFG_STEP_RIGHT) right_r <= cfg_wdata;
      end
    end
  end

  // cursor never leaves the screen
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n) col_r <= COL_MAX)
    else $error("cursor column beyond last column");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n) row_r <= ROW_MAX)
    else $error("cursor row beyond last row");

endmodule

>>> hw/rtl/aesi_queue.sv
// two-entry job queue between parser and result sequencer
module aesi_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  aesi_pkg::job_t  push_job,
  input  logic            pop,
  output aesi_pkg::job_t  head_job,
  output logic            full,
  output logic            not_empty
);

  localparam int DEPTH = 2;

  aesi_pkg::job_t   mem_r [DEPTH];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head_job  = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("job pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("job popped from an empty queue");

endmodule

>>> hw/rtl/aesi_back.sv
// result sequencer: spreads each job over one to three registered results
module aesi_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  aesi_pkg::job_t                  head_job,
  input  logic                            head_valid,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_handled,
  output logic [1:0]                      out_request_kind,
  output logic [aesi_pkg::NUM_W-1:0]      out_request_value,
  output logic [aesi_pkg::COL_W-1:0]      out_cursor_col_out,
  output logic [aesi_pkg::LROW_W-1:0]     out_cursor_row_out,
  output logic                            out_last_of_run
);

  logic [aesi_pkg::REQ_IDX_W-1:0]  idx_r;
  logic                            out_valid_r;
  logic                            handled_r;
  aesi_pkg::req_kind_t             kind_r;
  logic [aesi_pkg::NUM_W-1:0]      value_r;
  logic [aesi_pkg::COL_W-1:0]      col_r;
  logic [aesi_pkg::LROW_W-1:0]     row_r;
  logic                            last_r;
  logic                            load;

  // take the next result when the output register is free or being drained
  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (idx_r == head_job.last_idx);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= pop ? '0 : idx_r + 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      handled_r <= head_job.handled;
      kind_r    <= head_job.kind[idx_r];
      value_r   <= head_job.value[idx_r];
      col_r     <= head_job.col;
      row_r     <= head_job.row[aesi_pkg::LROW_W-1:0];
      last_r    <= pop;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_handled        = handled_r;
  assign out_request_kind   = kind_r;
  assign out_request_value  = value_r;
  assign out_cursor_col_out = col_r;
  assign out_cursor_row_out = row_r;
  assign out_last_of_run    = last_r;

  a_mid_run_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (idx_r != '0))
    else $error("result index lost inside a run");

endmodule

>>> hw/rtl/ansi_escape_sequence_interpreter.sv
// top level of the escape sequence interpreter: parser, job queue, result sequencer
//
// channel   direction  handshake            payload
// in_       input      in_valid/in_ready    mode, char_code, load_col, load_row
// out_      output     out_valid/out_ready  handled, request kind/value, cursor, last
// cfg_      input      cfg_we               cfg_index, cfg_wdata (step limits)
//
// one input transaction is taken per cycle while the two-entry job queue has room
// each transaction yields one to three results, one per cycle if out_ready stays high
// an input transaction is written into the job queue, and the output register takes
// each result from the queue head, so results pass through both registers
// synchronous active-low reset clears parser, cursor and saved cursor, and reloads
// the default step limits
// a stalled output fills the queue, then in_ready drops until results drain
module ansi_escape_sequence_interpreter #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aesi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [aesi_pkg::COL_W-1:0]       cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [aesi_pkg::CHAR_W-1:0]      in_char_code,
  input  logic [aesi_pkg::COL_W-1:0]       in_load_col,
  input  logic [aesi_pkg::LROW_W-1:0]      in_load_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_handled,
  output logic [1:0]                       out_request_kind,
  output logic [aesi_pkg::NUM_W-1:0]       out_request_value,
  output logic [aesi_pkg::COL_W-1:0]       out_cursor_col_out,
  output logic [aesi_pkg::LROW_W-1:0]      out_cursor_row_out,
  output logic                             out_last_of_run
);

  aesi_pkg::job_t  new_job;
  aesi_pkg::job_t  head_job;
  logic            accept;
  logic            q_full;
  logic            q_not_empty;
  logic            q_pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // classify the transaction and update parser state
  aesi_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .mode      (in_mode),
    .char_code (in_char_code),
    .load_col  (in_load_col),
    .load_row  (in_load_row),
    .job       (new_job)
  );

  // decouple parser from result delivery
  aesi_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_job  (new_job),
    .pop       (q_pop),
    .head_job  (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // emit results
  aesi_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head_job           (head_job),
    .head_valid         (q_not_empty),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_handled        (out_handled),
    .out_request_kind   (out_request_kind),
    .out_request_value  (out_request_value),
    .out_cursor_col_out (out_cursor_col_out),
    .out_cursor_row_out (out_cursor_row_out),
    .out_last_of_run    (out_last_of_run)
  );

endmodule
